### hdl/modular_exponentiation_unit_defines.svh
`ifndef MODULAR_EXPONENTIATION_UNIT_DEFINES_SVH
`define MODULAR_EXPONENTIATION_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define MEXP_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define MEXP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/mexp_pkg.sv
package mexp_pkg;

    localparam int WIDTH = 16;
    localparam int CNT_W = $clog2(WIDTH);

    typedef logic [WIDTH-1:0] t_word;
    typedef logic [WIDTH:0]   t_wide;
    typedef logic [CNT_W-1:0] t_cnt;

    typedef struct packed {
        logic busy;
        logic done;
    } t_mul_stat;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_REDUCE = 5'b00010,
        S_ACC    = 5'b00100,
        S_SQ     = 5'b01000,
        S_FINISH = 5'b10000
    } t_state;

    // (x + y) mod m for x, y below m
    function automatic t_word add_mod(t_word x, t_word y, t_word m);
        t_wide s;
        s = {1'b0, x} + {1'b0, y};
        if (s >= {1'b0, m}) begin
            s = s - {1'b0, m};
        end
        return s[WIDTH-1:0];
    endfunction

endpackage

### hdl/mexp_in_if.sv
interface mexp_in_if import mexp_pkg::*; ();
    logic  valid;
    logic  ready;
    t_word base;
    t_word exponent;

    modport source (output valid, output base, output exponent, input ready);
    modport sink (input valid, input base, input exponent, output ready);
endinterface

### hdl/mexp_out_if.sv
interface mexp_out_if import mexp_pkg::*; ();
    logic  valid;
    logic  ready;
    t_word power;

    modport source (output valid, output power, input ready);
    modport sink (input valid, input power, output ready);
endinterface

### hdl/mexp_mulmod.sv
module mexp_mulmod import mexp_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_start,
    input  t_word     i_a,
    input  t_word     i_b,
    input  t_word     i_mod,
    output t_mul_stat o_stat,
    output t_word     o_result
);

    logic  r_busy;
    logic  r_done;
    t_cnt  r_cnt;
    t_word r_a;
    t_word r_b;
    t_word r_r;

    t_word dbl;
    t_word n_r;

    // one bit of the multiplier per cycle, msb first
    always_comb begin
        dbl = add_mod(r_r, r_r, i_mod);
        n_r = add_mod(dbl, r_b[WIDTH-1] ? r_a : '0, i_mod);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            if (i_start) begin
                r_busy <= 1'b1;
                r_done <= 1'b0;
                r_cnt  <= CNT_W'(WIDTH - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_done <= 1'b0;
                    r_cnt  <= r_cnt - 1'b1;
                end
            end else begin
                r_done <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= i_a;
            r_b <= i_b;
            r_r <= '0;
        end else if (r_busy) begin
            r_b <= {r_b[WIDTH-2:0], 1'b0};
            r_r <= n_r;
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_result    = r_r;

endmodule

### hdl/modular_exponentiation_unit.sv
// Modular exponentiation unit: power = base ** exponent mod modulus.
// Input channel i_in carries base and exponent; a transaction is taken when
// valid and ready are both high. Output channel o_out carries power.
// The modulus is written through i_cfg_wr_en / i_cfg_wr_data; the user must
// write it only while the block is idle, as the block does not enforce this.
// It applies to every later transaction; a modulus below 2 gives 0.
// One transaction at a time: i_in.ready is high only while the sequencer idles.
// All arithmetic runs on one bit-serial modular multiplier that handles one
// multiplier bit per cycle. A transaction needs one reduction of the base,
// WIDTH - 1 squarings and one multiply per set exponent bit. The result sits in
// an output register; if the receiver stalls, the next transaction still runs
// and waits at its end until the register frees. Synchronous active-low reset
// returns the sequencer to idle, drops o_out.valid and sets the modulus to 2.
`include "modular_exponentiation_unit_defines.svh"

module modular_exponentiation_unit import mexp_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_cfg_wr_en,
    input  t_word   i_cfg_wr_data,
    mexp_in_if.sink   i_in,
    mexp_out_if.source o_out
);

    t_state r_state, n_state;
    t_word  r_modulus;
    t_word  r_exp, n_exp;
    t_word  r_acc, n_acc;
    t_word  r_sq, n_sq;
    t_cnt   r_bit, n_bit;
    logic   r_start, n_start;
    t_word  r_op_a, n_op_a;
    t_word  r_op_b, n_op_b;
    logic   r_out_valid, n_out_valid;
    t_word  r_out_power, n_out_power;

    t_mul_stat mul_stat;
    t_word     mul_result;
    logic      in_take;
    logic      out_load;
    logic      last_bit;
    logic      next_last;

    mexp_mulmod u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_start),
        .i_a      (r_op_a),
        .i_b      (r_op_b),
        .i_mod    (r_modulus),
        .o_stat   (mul_stat),
        .o_result (mul_result)
    );

    assign in_take   = i_in.valid && (r_state == S_IDLE);
    assign last_bit  = (r_bit == CNT_W'(WIDTH - 1));
    assign next_last = ((r_bit + 1'b1) == CNT_W'(WIDTH - 1));
    assign out_load  = (r_state == S_FINISH) && (!r_out_valid || o_out.ready);

    always_comb begin
        n_state     = r_state;
        n_exp       = r_exp;
        n_acc       = r_acc;
        n_sq        = r_sq;
        n_bit       = r_bit;
        n_start     = 1'b0;
        n_op_a      = r_op_a;
        n_op_b      = r_op_b;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_power = r_out_power;
        unique case (r_state)
            S_IDLE: begin
                if (in_take) begin
                    n_exp = i_in.exponent;
                    if (r_modulus < WIDTH'(2)) begin
                        n_acc   = '0;
                        n_state = S_FINISH;
                    end else begin
                        n_op_a  = WIDTH'(1);
                        n_op_b  = i_in.base;
                        n_start = 1'b1;
                        n_state = S_REDUCE;
                    end
                end
            end
            S_REDUCE: begin
                if (mul_stat.done) begin
                    n_sq  = mul_result;
                    n_acc = WIDTH'(1);
                    n_bit = '0;
                    if (r_exp[0]) begin
                        n_op_a  = WIDTH'(1);
                        n_op_b  = mul_result;
                        n_start = 1'b1;
                        n_state = S_ACC;
                    end else begin
                        n_op_a  = mul_result;
                        n_op_b  = mul_result;
                        n_start = 1'b1;
                        n_state = S_SQ;
                    end
                end
            end
            S_ACC: begin
                if (mul_stat.done) begin
                    n_acc = mul_result;
                    if (last_bit) begin
                        n_state = S_FINISH;
                    end else begin
                        n_op_a  = r_sq;
                        n_op_b  = r_sq;
                        n_start = 1'b1;
                        n_state = S_SQ;
                    end
                end
            end
            S_SQ: begin
                if (mul_stat.done) begin
                    n_sq  = mul_result;
                    n_bit = r_bit + 1'b1;
                    if (r_exp[r_bit + 1'b1]) begin
                        n_op_a  = r_acc;
                        n_op_b  = mul_result;
                        n_start = 1'b1;
                        n_state = S_ACC;
                    end else if (next_last) begin
                        n_state = S_FINISH;
                    end else begin
                        n_op_a  = mul_result;
                        n_op_b  = mul_result;
                        n_start = 1'b1;
                        n_state = S_SQ;
                    end
                end
            end
            S_FINISH: begin
                if (out_load) begin
                    n_out_valid = 1'b1;
                    n_out_power = r_acc;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_start     <= 1'b0;
            r_out_valid <= 1'b0;
            r_modulus   <= WIDTH'(2);
        end else begin
            r_state     <= n_state;
            r_start     <= n_start;
            r_out_valid <= n_out_valid;
            if (i_cfg_wr_en) begin
                r_modulus <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_exp       <= n_exp;
        r_acc       <= n_acc;
        r_sq        <= n_sq;
        r_bit       <= n_bit;
        r_op_a      <= n_op_a;
        r_op_b      <= n_op_b;
        r_out_power <= n_out_power;
    end

    assign i_in.ready  = (r_state == S_IDLE);
    assign o_out.valid = r_out_valid;
    assign o_out.power = r_out_power;

    `MEXP_ASSERT_NEXT(a_take_leaves_idle, in_take, r_state != S_IDLE, "transaction taken but idle")
    `MEXP_ASSERT_SAME(a_start_when_free, r_start, !mul_stat.busy, "multiplier restarted while busy")
    `MEXP_ASSERT_SAME(a_done_in_mul_state, mul_stat.done,
        r_state == S_REDUCE || r_state == S_ACC || r_state == S_SQ, "stray multiplier done")
    `MEXP_ASSERT_SAME(a_result_below_mod, out_load && (r_modulus >= WIDTH'(2)),
        r_acc < r_modulus, "result not reduced")

endmodule

### test/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import mexp_pkg::*;

    localparam int HOLD_CYCLES    = 3000;
    localparam int SETTLE_CYCLES  = 4;
    localparam int END_CYCLES     = 600;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int RANDOM_PHASES  = 10;

    class power_scoreboard;
        t_word modulus;
        t_word want_q[$];
        int    errors;

        function new();
            modulus = t_word'(2);
            errors  = 0;
        endfunction

        // square-and-multiply over the exponent bits, lsb first
        function t_word predict_power(t_word b, t_word e);
            logic [2*WIDTH-1:0] acc;
            logic [2*WIDTH-1:0] sq;
            logic [2*WIDTH-1:0] m;
            if (modulus < t_word'(2)) begin
                return '0;
            end
            m   = {{WIDTH{1'b0}}, modulus};
            acc = 1;
            sq  = {{WIDTH{1'b0}}, b} % m;
            for (int i = 0; i < WIDTH; i++) begin
                if (e[i]) begin
                    acc = (acc * sq) % m;
                end
                sq = (sq * sq) % m;
            end
            return acc[WIDTH-1:0];
        endfunction

        function void note_input(t_word b, t_word e);
            want_q.push_back(predict_power(b, e));
        endfunction

        function int pending();
            return want_q.size();
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        task check_power(t_word p);
            t_word want;
            if (want_q.size() == 0) begin
                report($sformatf("power %0d with no transaction outstanding", p));
            end else begin
                want = want_q.pop_front();
                if (p !== want) begin
                    report($sformatf("power got %0d, want %0d", p, want));
                end
            end
        endtask

        task check_drained();
            if (want_q.size() != 0) begin
                report($sformatf("%0d results never arrived", want_q.size()));
            end
        endtask
    endclass

    logic  i_clk;
    logic  i_rst_n;
    logic  cfg_wr_en;
    t_word cfg_wr_data;

    mexp_in_if  in_ch();
    mexp_out_if out_ch();

    modular_exponentiation_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_in          (in_ch),
        .o_out         (out_ch)
    );

    power_scoreboard powers = new();

    bit tx_idle_on;
    bit rx_idle_on;
    int hold_seq;
    int hold_seen;
    int hold_left;
    int stall_left;
    int idle_cycles;

    initial begin
        i_clk = 1'b0;
        forever begin
            #5 i_clk = ~i_clk;
        end
    end

    // mostly short gaps, a few long ones
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end else if (r < 98) begin
            return $urandom_range(4, 20);
        end
        return $urandom_range(50, 300);
    endfunction

    task automatic send_item(input t_word b, input t_word e);
        int gap;
        gap = tx_idle_on ? gap_len() : 0;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.base     <= b;
        in_ch.exponent <= e;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        powers.note_input(b, e);
    endtask

    task automatic write_modulus(input t_word m);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= m;
        @(posedge i_clk);
        cfg_wr_en <= 1'b0;
        powers.modulus = m;
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (powers.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic send_random_item();
        t_word b;
        t_word e;
        int    r;
        b = t_word'($urandom);
        e = t_word'($urandom);
        r = $urandom_range(0, 9);
        case (r)
            0: begin
                if (powers.modulus != '0) begin
                    b = t_word'(powers.modulus * $urandom_range(0, 65535 / powers.modulus));
                end
            end
            1: e = '0;
            2: b = ($urandom_range(0, 1) == 0) ? t_word'(0) : '1;
            3: e = ($urandom_range(0, 1) == 0) ? t_word'(1) : '1;
            default: ;
        endcase
        send_item(b, e);
    endtask

    // result side: checks transactions, stalls at random or holds off on request
    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_ch.valid && out_ch.ready) begin
                powers.check_power(out_ch.power);
            end
            if (hold_seq != hold_seen) begin
                hold_seen = hold_seq;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
                if (rx_idle_on && $urandom_range(0, 3) == 0) begin
                    stall_left = gap_len();
                end
            end
        end
    end

    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial begin
        t_word m;
        int    n;
        i_rst_n        <= 1'b0;
        cfg_wr_en      <= 1'b0;
        cfg_wr_data    <= '0;
        in_ch.valid    <= 1'b0;
        in_ch.base     <= '0;
        in_ch.exponent <= '0;
        rx_idle_on     <= 1'b1;
        hold_seq       <= 0;
        tx_idle_on = 1'b1;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset modulus
        send_item(16'd3, 16'd5);
        send_item(16'd4, 16'd0);
        send_item(16'hFFFF, 16'hFFFF);
        wait_drained();

        write_modulus(16'd65521);
        send_item(16'd0, 16'd0);
        send_item(16'd0, 16'hFFFF);
        send_item(16'hFFFF, 16'hFFFF);
        send_item(16'd65521, 16'd0);
        send_item(16'd65521, 16'd7);
        send_item(16'd2, 16'hFFFF);
        send_item(16'd1, 16'd1);
        send_item(16'hFFFF, 16'd1);
        send_item(16'd12345, 16'd2);
        wait_drained();

        write_modulus(16'hFFFF);
        send_item(16'hFFFF, 16'd3);
        send_item(16'hFFFE, 16'hFFFF);
        send_item(16'd256, 16'd2);
        wait_drained();

        // degenerate moduli
        write_modulus(16'd1);
        send_item(16'd5, 16'd0);
        send_item(16'hFFFF, 16'hFFFF);
        wait_drained();

        write_modulus(16'd0);
        send_item(16'd7, 16'd3);
        send_item(16'd0, 16'd0);
        wait_drained();

        write_modulus(16'd3);
        send_item(16'hFFFF, 16'd1);
        send_item(16'd2, 16'hFFFF);
        wait_drained();

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0:       m = 16'hFFFF;
                3:       m = 16'd2;
                6:       m = t_word'($urandom_range(3, 40));
                8:       m = 16'd1;
                9:       m = 16'd0;
                default: m = t_word'($urandom_range(2, 65535));
            endcase
            n = (phase >= 8) ? 30 : 120;
            tx_idle_on = (phase != 1 && phase != 4);
            rx_idle_on <= (phase != 1 && phase != 4);
            write_modulus(m);
            if (phase == 2) begin
                tx_idle_on = 1'b0;
                hold_seq <= hold_seq + 1;
            end
            for (int i = 0; i < n; i++) begin
                send_random_item();
            end
            wait_drained();
        end

        repeat (END_CYCLES) @(posedge i_clk);
        powers.check_drained();
        if (powers.errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+hdl
hdl/mexp_pkg.sv
hdl/mexp_in_if.sv
hdl/mexp_out_if.sv
hdl/mexp_mulmod.sv
hdl/modular_exponentiation_unit.sv
test/testbench.sv
